/* rtl/sfd_pkg.sv */
// Package: frame layout constants and types for the serial frame decoder.
`default_nettype none
package sfd_pkg;

   localparam int FRAME_BYTES  = 25;
   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_BITS    = 11;
   localparam int FIRST_DATA   = 1;
   localparam int LAST_DATA    = 22;
   localparam int FLAG_BYTE    = 23;
   localparam int FAILSAFE_BIT = 3;
   localparam int LOST_BIT     = 2;
   localparam int BANK_DEPTH   = 32;
   localparam int IDX_W        = $clog2(BANK_DEPTH);
   localparam int ADDR_W       = IDX_W + 1;
   localparam int ACC_W        = CHAN_BITS + 7;
   localparam int CNT_W        = $clog2(CHAN_BITS);

   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE   = 8'h00;

   typedef logic [7:0]              byte_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CHAN_BITS-1:0]    chan_type;
   typedef logic [3:0]              chan_idx_type;
   typedef logic [ACC_W-1:0]        acc_type;
   typedef logic [CNT_W-1:0]        cnt_type;

endpackage
`default_nettype wire

/* rtl/sbus_frame_decoder.sv */
// Top level: collects 25-byte frames into a banked store and unpacks 16 channels.
//
//  channel | direction | payload                                   | handshake
//  req     | in        | rx_byte[7:0]                              | req_valid / req_stall
//  rsp     | out       | channel_index, channel_value, flags, last | rsp_valid / rsp_stall
//
// One byte beat is taken per cycle unless req stalls. A good frame yields 16
// channel beats, at most one per cycle while rsp is free; the 22 data bytes are
// read back through the store's single read port, one byte a cycle unless rsp stalls.
// Two banks let the next frame collect while the previous one drains; req stalls
// only while idle between frames with both banks full. Reset is synchronous; the store
// itself needs no clearing as only fully written frames are read.
`default_nettype none
module sbus_frame_decoder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  sfd_pkg::byte_type req_rx_byte,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output sfd_pkg::chan_idx_type rsp_channel_index,
   output sfd_pkg::chan_type    rsp_channel_value,
   output logic                 rsp_failsafe_flag,
   output logic                 rsp_lost_flag,
   output logic                 rsp_last_of_frame
);
   import sfd_pkg::*;

   // frame store, two banks
   byte_type mem [2*BANK_DEPTH];

   // collection side
   logic       collecting_ff, collecting_in;
   logic [4:0] byte_count_ff, byte_count_in;
   logic       wr_bank_ff, wr_bank_in;
   logic [1:0] busy_ff, busy_in;
   logic [1:0] fs_ff, lost_ff;
   logic       req_accept, mem_we, frame_done;
   addr_type   wr_addr;

   // read-back side
   logic       rd_bank_ff, rd_bank_in;
   logic [4:0] rd_idx_ff, rd_idx_in;
   byte_type   q_ff;
   logic       q_vld_ff, q_vld_in;
   acc_type    acc_ff, acc_in, acc_new;
   cnt_type    acc_cnt_ff, acc_cnt_in;
   chan_idx_type ch_ff, ch_in;
   logic       rd_en, consume, produce, out_free, drain_done;

   // output register
   logic         rsp_valid_ff;
   chan_idx_type rsp_index_ff;
   chan_type     rsp_value_ff;
   logic         rsp_fs_ff, rsp_lost_ff, rsp_last_ff;

   // a start byte may not open a bank that still awaits draining
   assign req_stall  = !collecting_ff && busy_ff[wr_bank_ff];
   assign req_accept = req_valid && !req_stall;
   assign mem_we     = req_accept && (collecting_ff || (req_rx_byte == START_BYTE));
   assign wr_addr    = {wr_bank_ff, collecting_ff ? byte_count_ff : idx_type'(0)};
   assign frame_done = req_accept && collecting_ff &&
                       (byte_count_ff == 5'(FRAME_BYTES - 1));

   always_comb begin
      collecting_in = collecting_ff;
      byte_count_in = byte_count_ff;
      wr_bank_in    = wr_bank_ff;
      busy_in       = busy_ff;
      if (req_accept) begin
         if (!collecting_ff) begin
            if (req_rx_byte == START_BYTE) begin
               collecting_in = 1'b1;
               byte_count_in = 5'd1;
            end
         end else if (frame_done) begin
            collecting_in = 1'b0;
            byte_count_in = 5'd0;
            if (req_rx_byte == END_BYTE) begin
               busy_in[wr_bank_ff] = 1'b1;
               wr_bank_in          = !wr_bank_ff;
            end
         end else begin
            byte_count_in = byte_count_ff + 5'd1;
         end
      end
      if (drain_done)
         busy_in[rd_bank_ff] = 1'b0;
   end

   // read-back and unpack
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign produce    = q_vld_ff && (acc_cnt_ff >= cnt_type'(CHAN_BITS - 8));
   assign consume    = q_vld_ff && ((acc_cnt_ff < cnt_type'(CHAN_BITS - 8)) || out_free);
   assign drain_done = consume && produce && (ch_ff == chan_idx_type'(NUM_CHANNELS - 1));
   assign rd_en      = busy_ff[rd_bank_ff] && (rd_idx_ff <= 5'(LAST_DATA)) &&
                       (!q_vld_ff || consume);
   assign acc_new    = acc_ff | (acc_type'(q_ff) << acc_cnt_ff);

   always_comb begin
      rd_bank_in = rd_bank_ff;
      rd_idx_in  = rd_idx_ff;
      q_vld_in   = q_vld_ff;
      acc_in     = acc_ff;
      acc_cnt_in = acc_cnt_ff;
      ch_in      = ch_ff;
      if (consume)
         q_vld_in = 1'b0;
      if (rd_en) begin
         q_vld_in  = 1'b1;
         rd_idx_in = rd_idx_ff + 5'd1;
      end
      if (consume) begin
         if (produce) begin
            acc_in     = acc_new >> CHAN_BITS;
            acc_cnt_in = acc_cnt_ff - cnt_type'(CHAN_BITS - 8);
            ch_in      = ch_ff + 4'd1;
         end else begin
            acc_in     = acc_new;
            acc_cnt_in = acc_cnt_ff + cnt_type'(8);
         end
      end
      if (drain_done) begin
         rd_bank_in = !rd_bank_ff;
         rd_idx_in  = 5'(FIRST_DATA);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[wr_addr] <= req_rx_byte;
      if (rd_en)
         q_ff <= mem[{rd_bank_ff, rd_idx_ff}];
   end

   always_ff @(posedge clock) begin
      if (req_accept && collecting_ff && (byte_count_ff == 5'(FLAG_BYTE))) begin
         fs_ff[wr_bank_ff]   <= req_rx_byte[FAILSAFE_BIT];
         lost_ff[wr_bank_ff] <= req_rx_byte[LOST_BIT];
      end
      if (consume && produce) begin
         rsp_index_ff <= ch_ff;
         rsp_value_ff <= acc_new[CHAN_BITS-1:0];
         rsp_fs_ff    <= fs_ff[rd_bank_ff];
         rsp_lost_ff  <= lost_ff[rd_bank_ff];
         rsp_last_ff  <= (ch_ff == chan_idx_type'(NUM_CHANNELS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         byte_count_ff <= 5'd0;
         wr_bank_ff    <= 1'b0;
         busy_ff       <= 2'b00;
         rd_bank_ff    <= 1'b0;
         rd_idx_ff     <= 5'(FIRST_DATA);
         q_vld_ff      <= 1'b0;
         acc_ff        <= '0;
         acc_cnt_ff    <= '0;
         ch_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         byte_count_ff <= byte_count_in;
         wr_bank_ff    <= wr_bank_in;
         busy_ff       <= busy_in;
         rd_bank_ff    <= rd_bank_in;
         rd_idx_ff     <= rd_idx_in;
         q_vld_ff      <= q_vld_in;
         acc_ff        <= acc_in;
         acc_cnt_ff    <= acc_cnt_in;
         ch_ff         <= ch_in;
         if (consume && produce)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_failsafe_flag = rsp_fs_ff;
   assign rsp_lost_flag     = rsp_lost_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // the bank being filled is never one still awaiting readback
   a_no_bank_clash: assert property (@(posedge clock) disable iff (reset)
      collecting_ff |-> !busy_ff[wr_bank_ff])
      else $error("frame bank filled while still pending");

   // every frame consumes exactly its data bits
   a_acc_empty: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> (acc_cnt_ff == '0) && (acc_ff == '0))
      else $error("bit accumulator not empty at end of frame");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_frame) |-> (rsp_channel_index == 4'hF))
      else $error("last-of-frame beat on wrong channel");

   a_rd_after_data: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff >= 5'(FIRST_DATA)))
      else $error("read of header byte");

endmodule
`default_nettype wire
